[hdl/uwsc_pkg.sv]
// ----------------------------------------------------------------------------
// uwsc_pkg: shared types for the compacting unique word set
// Status codes, sequencer states and the control bundle broadcast to cells.
// ----------------------------------------------------------------------------
package uwsc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 7;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ZERO     = 3'd5
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              cmp_en;     // latch match against cmp_value
    logic [WORD_W-1:0] cmp_value;
    logic              ins_en;     // first empty cell takes ins_value
    logic [WORD_W-1:0] ins_value;
    logic              rm_en;      // matching cell opens a hole
  } cell_ctrl_t;

endpackage

[hdl/uwsc_cell.sv]
// ----------------------------------------------------------------------------
// uwsc_cell: one entry of the compacting table
// Holds a word, compares it with the broadcast word, takes an insert when it
// is the first empty entry, and pulls its upper neighbor down during a remove.
// ----------------------------------------------------------------------------
module uwsc_cell
  import uwsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic              down_occ,   // lower neighbor occupied
  input  logic              down_pull,  // lower neighbor is pulling this word
  input  logic [WORD_W-1:0] up_word,    // upper neighbor word
  output logic [WORD_W-1:0] word,
  output logic              occ,
  output logic              match,
  output logic              pull
);

  assign occ = (word != '0);

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= occ && (word == ctrl.cmp_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
      pull <= 1'b0;
    end else begin
      priority if (pull) begin
        // hole moves up one place per cycle
        word <= up_word;
        pull <= 1'b0;
      end else if (down_pull) begin
        pull <= occ;
      end else if (ctrl.rm_en) begin
        pull <= match;
      end else if (ctrl.ins_en && !occ && down_occ) begin
        word <= ctrl.ins_value;
      end else begin
        // hold
        word <= word;
      end
    end
  end

endmodule

[hdl/unique_word_set_compacting.sv]
// ----------------------------------------------------------------------------
// unique_word_set_compacting: packed table of distinct nonzero words
// Insert adds a word at the first empty entry unless present or full;
// remove closes the gap by moving later entries down one place.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------
//  request | req_valid/req_stall| command (1b), value (32b)
//  result  | rsp_valid/rsp_stall| status (3b), occupancy (7b)
//
// Sequence: the accept edge registers a match bit in every cell; the decide
// step then updates the table and loads the result register. An insert, a
// zero word or a remove of an absent word then returns to idle; a remove
// that hits enters the shift state, where the hole climbs the cell row one
// place per cycle until no cell is still pulling.
// Reset: rst clears every entry and the count.
// Stalls: a result waits in the output register; the sequencer holds in its
// decide state while that register holds a result that is stalled.
// ----------------------------------------------------------------------------
module unique_word_set_compacting
  import uwsc_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                command,
  input  logic [WORD_W-1:0]   value,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [OCC_W-1:0]    occupancy
);

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt;
  cmd_t               cmd_q;
  logic [WORD_W-1:0]  value_q;
  cell_ctrl_t         ctrl;

  logic [WORD_W-1:0]  word_vec [SLOTS];
  logic [SLOTS-1:0]   occ_vec;
  logic [SLOTS-1:0]   match_vec;
  logic [SLOTS-1:0]   pull_vec;

  logic               accept;
  logic               exec_go;
  logic               found;
  logic               is_zero;
  logic               is_full;
  status_t            status_res;
  logic [CNT_W-1:0]   cnt_res;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  // new word only while the sequencer is idle
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // decide step runs once the output register can take the result
  assign exec_go = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign found   = |match_vec;
  assign is_zero = (value_q == '0);
  assign is_full = (cnt == CNT_W'(SLOTS));

  // compare happens on the accept edge against the port word directly
  assign ctrl.cmp_en    = accept;
  assign ctrl.cmp_value = value;
  assign ctrl.ins_en    = exec_go && !is_zero && (cmd_q == CMD_INSERT) && !found
                          && !is_full;
  assign ctrl.ins_value = value_q;
  assign ctrl.rm_en     = exec_go && !is_zero && (cmd_q == CMD_REMOVE) && found;

  // status and new count for the word in the decide step
  always_comb begin
    status_res = ST_ZERO;
    cnt_res    = cnt;
    priority if (is_zero) begin
      status_res = ST_ZERO;
    end else if (cmd_q == CMD_INSERT) begin
      priority if (found) begin
        status_res = ST_PRESENT;
      end else if (is_full) begin
        status_res = ST_FULL;
      end else begin
        status_res = ST_INSERTED;
        cnt_res    = cnt + CNT_W'(1);
      end
    end else begin
      if (found) begin
        status_res = ST_REMOVED;
        cnt_res    = cnt - CNT_W'(1);
      end else begin
        status_res = ST_NOTFOUND;
      end
    end
  end

  // occupancy port carries the count modulo 128
  assign cnt_ext = {{OCC_W{1'b0}}, cnt_res};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = ctrl.rm_en ? S_SHIFT : S_IDLE;
        end
      end
      S_SHIFT: begin
        // hole has reached the top of the occupied run
        if (pull_vec == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        cnt       <= cnt_res;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd_t'(command);
      value_q <= value;
    end
    if (exec_go) begin
      status    <= status_res;
      occupancy <= cnt_ext[OCC_W-1:0];
    end
  end

  // row of cells; cell 0 is the bottom of the table
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic              down_occ;
    logic              down_pull;
    logic [WORD_W-1:0] up_word;

    if (i == 0) begin : g_bottom
      assign down_occ  = 1'b1;
      assign down_pull = 1'b0;
    end else begin : g_inner
      assign down_occ  = occ_vec[i-1];
      assign down_pull = pull_vec[i-1];
    end

    if (i == SLOTS - 1) begin : g_top
      assign up_word = '0;
    end else begin : g_below
      assign up_word = word_vec[i+1];
    end

    uwsc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .down_occ  (down_occ),
      .down_pull (down_pull),
      .up_word   (up_word),
      .word      (word_vec[i]),
      .occ       (occ_vec[i]),
      .match     (match_vec[i]),
      .pull      (pull_vec[i])
    );
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for unique_word_set_compacting
// Sends insert and remove words and predicts each status and occupancy from a
// local copy of the packed set. Results are checked in order against the
// expected queue, with random idles and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import uwsc_pkg::*;

  localparam int unsigned SLOTS      = 64;
  localparam int unsigned POOL_SIZE  = 96;    // more than SLOTS so the set can fill up
  localparam int          WATCHDOG   = 3000;  // cycles with no handshake on either side
  localparam int          LONG_HOLD  = 400;   // receiver back-pressure burst
  localparam int          TAIL_WAIT  = 80;    // longest remove shifts SLOTS-1 entries

  // one request word as queued for the driver
  typedef struct {
    cmd_t              op;
    logic [WORD_W-1:0] data;
    bit                drain_first;  // hold this word until all results are back
  } set_request_t;

  // one predicted result word
  typedef struct {
    status_t          st;
    logic [OCC_W-1:0] occ;
  } set_result_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic                command   = CMD_INSERT;
  logic [WORD_W-1:0]   value     = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  unique_word_set_compacting #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .command  (command),
    .value    (value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (status),
    .occupancy(occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the packed set: occupied entries first, count of them separate.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] shadow_set [SLOTS];
  int                shadow_count = 0;

  set_request_t request_queue [$];
  set_result_t  expected_results [$];
  logic [WORD_W-1:0] word_pool [POOL_SIZE];

  int mismatches  = 0;
  int sent_words  = 0;
  int recv_words  = 0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int hold_left   = 0;
  int idle_cycles = 0;
  bit req_fire;
  set_request_t next_req;
  set_result_t  exp_res;

  // Apply one request to the shadow set and return the status it should give.
  function automatic set_result_t apply_to_set(cmd_t op, logic [WORD_W-1:0] w);
    set_result_t r;
    int          hit;
    hit = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_set[i] == w) hit = i;
    if (w == '0) begin
      r.st = ST_ZERO;                 // zero is never stored
    end else if (op == CMD_INSERT) begin
      if (hit >= 0) begin
        r.st = ST_PRESENT;
      end else if (shadow_count >= SLOTS) begin
        r.st = ST_FULL;               // no empty entry: word dropped
      end else begin
        shadow_set[shadow_count] = w;
        shadow_count++;
        r.st = ST_INSERTED;
      end
    end else if (hit < 0) begin
      r.st = ST_NOTFOUND;
    end else begin
      // close the hole: later entries move down one place
      for (int i = hit; i + 1 < shadow_count; i++)
        shadow_set[i] = shadow_set[i + 1];
      shadow_set[shadow_count - 1] = '0;
      shadow_count--;
      r.st = ST_REMOVED;
    end
    r.occ = OCC_W'(shadow_count);
    return r;
  endfunction

  task automatic push_request(cmd_t op, logic [WORD_W-1:0] w, bit drain_first = 1'b0);
    set_request_t q;
    q.op          = op;
    q.data        = w;
    q.drain_first = drain_first;
    request_queue.push_back(q);
  endtask

  // Random word: mostly from the pool so inserts and removes hit each other,
  // with a little zero and fully random noise.
  task automatic push_mixed();
    int   pick;
    cmd_t op;
    pick = $urandom_range(0, 99);
    op   = cmd_t'($urandom_range(0, 1));
    if (pick < 4)
      push_request(op, '0);
    else if (pick < 10)
      push_request(op, $urandom);
    else
      push_request(op, word_pool[$urandom_range(0, POOL_SIZE - 1)]);
  endtask

  // Every fourth block of 50 words runs with no random gaps on either side.
  function automatic bit back_to_back(int n);
    return ((n / 50) % 4) == 3;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers words from request_queue, predicts on every accepted word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      command   <= CMD_INSERT;
      value     <= '0;
      send_gap  = 0;
    end else begin
      req_fire = req_valid && !req_stall;
      if (req_fire) begin
        expected_results.push_back(apply_to_set(cmd_t'(command), value));
        sent_words++;
        send_gap = back_to_back(sent_words) ? 0 : $urandom_range(0, 19);
      end
      // payload only moves once the current word is gone
      if (!req_valid || req_fire) begin
        if (send_gap != 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (request_queue.size() != 0 &&
                     (!request_queue[0].drain_first || expected_results.size() == 0)) begin
          next_req  = request_queue.pop_front();
          req_valid <= 1'b1;
          command   <= next_req.op;
          value     <= next_req.data;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction and drives
  // rsp_stall, including two long hold-offs that back the block up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result status=%0d occupancy=%0d", status, occupancy);
        end else begin
          exp_res = expected_results.pop_front();
          if (status !== exp_res.st || occupancy !== exp_res.occ) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d: expected status=%0d occupancy=%0d, got status=%0d occupancy=%0d",
                       recv_words, exp_res.st, exp_res.occ, status, occupancy);
          end
        end
        recv_words++;
        recv_gap = back_to_back(recv_words) ? 0 : $urandom_range(0, 19);
        if (recv_words == 150 || recv_words == 600)
          hold_left = LONG_HOLD;
      end else if (hold_left != 0) begin
        hold_left--;
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      rsp_stall <= (hold_left != 0) || (recv_gap != 0);
    end
  end

  // Watchdog: a stretch with no handshake at all means the block hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == WATCHDOG) begin
          $display("FAIL unique_word_set_compacting");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    for (int i = 0; i < SLOTS; i++) shadow_set[i] = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      word_pool[i] = $urandom;
      while (word_pool[i] == '0) word_pool[i] = $urandom;
    end
    word_pool[0] = 32'h0000_0001;
    word_pool[1] = 32'hFFFF_FFFF;

    // directed: zero, empty set, field extremes, hits and misses, removes
    // from the front, the middle and the end
    push_request(CMD_INSERT, '0);
    push_request(CMD_REMOVE, '0);
    push_request(CMD_REMOVE, 32'h0000_0005);
    push_request(CMD_INSERT, 32'hFFFF_FFFF);
    push_request(CMD_INSERT, 32'h0000_0001);
    push_request(CMD_INSERT, 32'h8000_0000);
    push_request(CMD_INSERT, 32'h7FFF_FFFF);
    push_request(CMD_INSERT, 32'h0000_0001);
    push_request(CMD_INSERT, 32'hFFFF_FFFF);
    push_request(CMD_INSERT, '0);
    push_request(CMD_REMOVE, 32'h0000_0001);
    push_request(CMD_REMOVE, 32'h0000_0001);
    push_request(CMD_INSERT, 32'hAAAA_AAAA);
    push_request(CMD_INSERT, 32'h5555_5555);
    push_request(CMD_REMOVE, 32'h7FFF_FFFF);
    push_request(CMD_REMOVE, 32'h5555_5555);
    push_request(CMD_REMOVE, '0);
    push_request(CMD_REMOVE, 32'hFFFF_FFFF);
    push_request(CMD_REMOVE, 32'h8000_0000);
    push_request(CMD_REMOVE, 32'hAAAA_AAAA);
    push_request(CMD_REMOVE, 32'hAAAA_AAAA);

    // rounds: fill past full, mix, sweep removes from the fill's start or a random start, mix
    for (int r = 0; r < 4; r++) begin
      base = $urandom_range(0, POOL_SIZE - 1);
      for (int k = 0; k < 72; k++)
        push_request(CMD_INSERT, word_pool[(base + k) % POOL_SIZE], k == 0);
      for (int k = 0; k < 60; k++) push_mixed();
      base = $urandom_range(0, 1) ? base : $urandom_range(0, POOL_SIZE - 1);
      for (int k = 0; k < 72; k++)
        push_request(CMD_REMOVE, word_pool[(base + k) % POOL_SIZE]);
      for (int k = 0; k < 30; k++) push_mixed();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || req_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS unique_word_set_compacting");
    else
      $display("FAIL unique_word_set_compacting");
    $finish;
  end

endmodule

[files.f]
hdl/uwsc_pkg.sv
hdl/uwsc_cell.sv
hdl/unique_word_set_compacting.sv
tb/sv/tb.sv
